// ----- design/uri_percent_encoder_macros.svh -----
// Assertion macros shared by the URI percent encoder modules.
// Included by each module that carries concurrent checks; no other dependencies.
`ifndef URI_PERCENT_ENCODER_MACROS_SVH
`define URI_PERCENT_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- design/upe_pkg.sv -----
// Shared types and constants for the URI percent encoder.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps

package upe_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [1:0] {
      KIND_PASS   = 2'd0,
      KIND_ERROR  = 2'd1,
      KIND_ESCAPE = 2'd2
   } kind_type;

   // UTF-8 octets, first octet at index 0, last_idx = octet count - 1
   typedef struct packed {
      logic [3:0][7:0] octets;
      logic [1:0]      last_idx;
   } utf8_type;

   // one queued job for the back end
   typedef struct packed {
      kind_type   kind;
      logic [15:0] pass_char;
      utf8_type   seq;
   } desc_type;

endpackage

// ----- design/upe_front.sv -----
// Front end: accepts code units, tracks surrogate and error state, classifies.
// Pushes one job per item that yields results; depends on upe_pkg.
`timescale 1ns / 1ps
`include "uri_percent_encoder_macros.svh"

module upe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_data,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [15:0]       in_unit,
   input  logic              in_eos,
   input  logic              q_full,
   output logic              q_push,
   output upe_pkg::desc_type q_data
);
   import upe_pkg::*;

   logic        mode_ff, mode_in;
   logic        high_pending_ff, high_pending_in;
   logic [9:0]  high_bits_ff, high_bits_in;
   logic        failed_ff, failed_in;

   logic        accept;
   logic        hi_zero;
   logic [7:0]  c_lo;
   logic [7:0]  c_fold;
   logic        is_low, is_high;
   logic        is_mark, is_reserved, is_alnum, passes;
   logic        err;
   logic        has_res;
   logic [20:0] pair_cp;
   desc_type    desc;

   function automatic utf8_type utf8_encode(input logic [20:0] v);
      utf8_type r;
      r = '0;
      if (v < 21'h80) begin
         r.octets[0] = {1'b0, v[6:0]};
         r.last_idx  = 2'd0;
      end else if (v < 21'h800) begin
         r.octets[0] = {3'b110, v[10:6]};
         r.octets[1] = {2'b10, v[5:0]};
         r.last_idx  = 2'd1;
      end else if (v < 21'h10000) begin
         r.octets[0] = {4'b1110, v[15:12]};
         r.octets[1] = {2'b10, v[11:6]};
         r.octets[2] = {2'b10, v[5:0]};
         r.last_idx  = 2'd2;
      end else begin
         r.octets[0] = {5'b11110, v[20:18]};
         r.octets[1] = {2'b10, v[17:12]};
         r.octets[2] = {2'b10, v[11:6]};
         r.octets[3] = {2'b10, v[5:0]};
         r.last_idx  = 2'd3;
      end
      return r;
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   assign hi_zero = (in_unit[15:8] == 8'h00);
   assign c_lo    = in_unit[7:0];
   assign c_fold  = c_lo | 8'h20;
   assign is_low  = (in_unit >= 16'hdc00) && (in_unit <= 16'hdfff);
   assign is_high = (in_unit >= 16'hd800) && (in_unit <= 16'hdbff);

   assign is_mark = hi_zero && (c_lo == "-" || c_lo == "_" || c_lo == "." || c_lo == "!" ||
                                c_lo == "~" || c_lo == "*" || c_lo == "'" || c_lo == "(" ||
                                c_lo == ")");
   assign is_reserved = hi_zero && (c_lo == ";" || c_lo == "/" || c_lo == "?" ||
                                    c_lo == ":" || c_lo == "@" || c_lo == "&" ||
                                    c_lo == "=" || c_lo == "+" || c_lo == "$" ||
                                    c_lo == ",");
   assign is_alnum = hi_zero && ((c_lo >= "0" && c_lo <= "9") ||
                                 (c_fold >= "a" && c_fold <= "z"));
   assign passes = is_mark || is_alnum || (!mode_ff && (is_reserved || (hi_zero && c_lo == "#")));

   // join both surrogate payloads, then add the supplementary plane offset
   assign pair_cp = {1'b0, high_bits_ff, in_unit[9:0]} + 21'h10000;

   always_comb begin
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      failed_in       = failed_ff;
      err             = 1'b0;
      has_res         = 1'b0;
      desc            = '0;
      desc.kind       = KIND_PASS;
      desc.pass_char  = in_unit;
      if (failed_ff) begin
         has_res = 1'b0;
      end else if (high_pending_ff) begin
         high_pending_in = 1'b0;
         high_bits_in    = '0;
         if (is_low) begin
            has_res   = 1'b1;
            desc.kind = KIND_ESCAPE;
            desc.seq  = utf8_encode(pair_cp);
         end else begin
            err = 1'b1;
         end
      end else if (passes) begin
         has_res = 1'b1;
      end else if (is_low) begin
         err = 1'b1;
      end else if (is_high) begin
         if (in_eos) begin
            err = 1'b1;
         end else begin
            high_pending_in = 1'b1;
            high_bits_in    = in_unit[9:0];
         end
      end else begin
         has_res   = 1'b1;
         desc.kind = KIND_ESCAPE;
         desc.seq  = utf8_encode({5'd0, in_unit});
      end
      if (err) begin
         has_res         = 1'b1;
         desc.kind       = KIND_ERROR;
         failed_in       = 1'b1;
         high_pending_in = 1'b0;
         high_bits_in    = '0;
      end
      // string ends: next one starts clean
      if (in_eos) begin
         high_pending_in = 1'b0;
         high_bits_in    = '0;
         failed_in       = 1'b0;
      end
   end

   assign mode_in = csr_valid ? csr_data : mode_ff;
   assign q_push  = accept && has_res;
   assign q_data  = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
         failed_ff       <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            high_pending_ff <= high_pending_in;
            high_bits_ff    <= high_bits_in;
            failed_ff       <= failed_in;
         end
      end
   end

   `ASSERT_NEVER(a_hold_while_failed, clock, reset, high_pending_ff && failed_ff,
                 "high surrogate held inside a failed string")
   `ASSERT_PROP(a_eos_clears, clock, reset, (accept && in_eos) |=> (!high_pending_ff && !failed_ff),
                "state not cleared after end of string")

endmodule

// ----- design/upe_queue.sv -----
// Small job queue between front and back end.
// Register array with read and write pointers; depends on upe_pkg.
`timescale 1ns / 1ps
`include "uri_percent_encoder_macros.svh"

module upe_queue #(
   parameter int DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  upe_pkg::desc_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output upe_pkg::desc_type pop_data
);
   import upe_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   desc_type        slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_PROP(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff),
                "queue empty but pointers differ")

endmodule

// ----- design/upe_back.sv -----
// Back end: expands queued jobs into output characters, one per cycle while the output accepts them.
// Percent escapes are sequenced per octet; depends on upe_pkg.
`timescale 1ns / 1ps
`include "uri_percent_encoder_macros.svh"

module upe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  upe_pkg::desc_type q_data,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [15:0]       out_char,
   output logic              out_last,
   output logic              out_err
);
   import upe_pkg::*;

   typedef enum logic [2:0] {
      PH_PCT = 3'b001,
      PH_HI  = 3'b010,
      PH_LO  = 3'b100
   } phase_type;

   logic        cur_valid_ff, cur_valid_in;
   desc_type    cur_ff, cur_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;

   logic        valid_ff, valid_in;
   logic [15:0] char_ff, char_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;

   logic        emit;
   logic        cur_done;
   logic [7:0]  octet;

   function automatic logic [15:0] hex_digit(input logic [3:0] v);
      logic [7:0] d;
      d = (v < 4'd10) ? ("0" + {4'd0, v}) : ("A" + {4'd0, v} - 8'd10);
      return {8'h00, d};
   endfunction

   assign emit  = cur_valid_ff && (!valid_ff || out_ready);
   assign octet = cur_ff.seq.octets[idx_ff];

   always_comb begin
      char_in  = '0;
      last_in  = 1'b1;
      err_in   = 1'b0;
      cur_done = 1'b1;
      unique case (cur_ff.kind)
         KIND_PASS: begin
            char_in = cur_ff.pass_char;
         end
         KIND_ERROR: begin
            err_in = 1'b1;
         end
         KIND_ESCAPE: begin
            cur_done = (phase_ff == PH_LO) && (idx_ff == cur_ff.seq.last_idx);
            last_in  = cur_done;
            unique case (phase_ff)
               PH_PCT:  char_in = {8'h00, "%"};
               PH_HI:   char_in = hex_digit(octet[7:4]);
               PH_LO:   char_in = hex_digit(octet[3:0]);
               default: char_in = '0;
            endcase
         end
         default: begin
            char_in = '0;
         end
      endcase
   end

   // take the next job when none is held or the held one finishes now
   assign q_pop = q_not_empty && (!cur_valid_ff || (emit && cur_done));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_data;
         phase_in     = PH_PCT;
         idx_in       = '0;
      end else if (emit && cur_done) begin
         cur_valid_in = 1'b0;
         phase_in     = PH_PCT;
         idx_in       = '0;
      end else if (emit) begin
         unique case (phase_ff)
            PH_PCT:  phase_in = PH_HI;
            PH_HI:   phase_in = PH_LO;
            PH_LO: begin
               phase_in = PH_PCT;
               idx_in   = idx_ff + 2'd1;
            end
            default: phase_in = PH_PCT;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PH_PCT;
         idx_ff       <= '0;
         valid_ff     <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
         err_ff  <= err_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;
   assign out_err   = err_ff;

   `ASSERT_PROP(a_err_word, clock, reset, (valid_ff && err_ff) |-> (last_ff && char_ff == '0),
                "error word must be last and carry a zero character")
   `ASSERT_PROP(a_phase_plain, clock, reset,
                (cur_valid_ff && cur_ff.kind != KIND_ESCAPE) |-> (phase_ff == PH_PCT && idx_ff == '0),
                "sequencer moved on a plain job")

endmodule

// ----- design/uri_percent_encoder.sv -----
// URI percent encoder: UTF-16 code units in, escaped characters out. A code unit is
// accepted every cycle while the job queue has room; characters leave one per cycle
// on the result side while rsp_tready is high. A character in the unescaped set, or an
// error, yields one result word; an escaped character yields three words per UTF-8
// octet, as the back-end sequencer steps '%', high digit, low digit for each octet. A
// high surrogate that is held produces nothing. rsp_tlast marks the last word of each
// input word; rsp_tuser flags malformed surrogate input, after which the rest of the
// string is dropped. Write csr_data while the block is idle: 0 selects the full-URI
// set, 1 the component set.
`timescale 1ns / 1ps

module uri_percent_encoder #(
   parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_char
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser,   // [0] error_flag
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // component_mode
);
   import upe_pkg::*;

   logic     q_full, q_push, q_pop, q_not_empty;
   desc_type q_in, q_out;

   assign csr_ready = 1'b1;

   upe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_unit   (req_tdata),
      .in_eos    (req_tlast),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   upe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   upe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_out),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_char    (rsp_tdata),
      .out_last    (rsp_tlast),
      .out_err     (rsp_tuser)
   );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for the URI percent encoder: directed and random UTF-16 strings.
// Expected words come from an encoder model in this file; needs only the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [15:0] HIGH_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST   = 16'hDC00;
   localparam logic [15:0] LOW_LAST    = 16'hDFFF;
   localparam logic [15:0] PERCENT     = 16'h0025;
   localparam logic        MODE_FULL   = 1'b0;
   localparam logic        MODE_COMP   = 1'b1;
   localparam int          HOLD_CYCLES = 300;
   localparam int          SETTLE      = 24;
   localparam int          QUIET_LIMIT = 4000;

   typedef struct packed {
      logic [15:0] ch;
      logic        last;
      logic        err;
   } enc_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_data = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;
   wire         rsp_tlast;
   wire         rsp_tuser;
   wire         csr_ready;

   // encoder model state
   logic        comp_mode = MODE_FULL;
   logic        high_held = 1'b0;
   logic [9:0]  held_bits = '0;
   logic        str_failed = 1'b0;

   enc_word_type pending_words[$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          gaps_on = 1'b1;
   int          hold_asked = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   string       punct_set = "-_.!~*'();/?:@&=+$,#%";

   uri_percent_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------- encoder model ----------------

   function automatic logic [15:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? 16'h0030 + v : 16'h0037 + v;
   endfunction

   function automatic bit keeps_char(input logic [15:0] c);
      logic [15:0] lower;
      lower = c | 16'h0020;
      case (c)
         "-", "_", ".", "!", "~", "*", "'", "(", ")": return 1'b1;
         default: ;
      endcase
      if (c >= "0" && c <= "9") return 1'b1;
      if (lower >= "a" && lower <= "z") return 1'b1;
      if (comp_mode == MODE_COMP) return 1'b0;
      case (c)
         ";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic push_word(input logic [15:0] ch, input logic last, input logic err);
      enc_word_type w;
      w.ch = ch;
      w.last = last;
      w.err = err;
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic push_utf8(input logic [20:0] v);
      logic [7:0] oct [4];
      int n;
      if (v < 21'h80) begin
         n = 1;
         oct[0] = v[7:0];
      end else if (v < 21'h800) begin
         n = 2;
         oct[0] = {3'b110, v[10:6]};
         oct[1] = {2'b10, v[5:0]};
      end else if (v < 21'h10000) begin
         n = 3;
         oct[0] = {4'b1110, v[15:12]};
         oct[1] = {2'b10, v[11:6]};
         oct[2] = {2'b10, v[5:0]};
      end else begin
         n = 4;
         oct[0] = {5'b11110, v[20:18]};
         oct[1] = {2'b10, v[17:12]};
         oct[2] = {2'b10, v[11:6]};
         oct[3] = {2'b10, v[5:0]};
      end
      for (int i = 0; i < n; i++) begin
         push_word(PERCENT, 1'b0, 1'b0);
         push_word(hex_char(oct[i][7:4]), 1'b0, 1'b0);
         push_word(hex_char(oct[i][3:0]), i == n - 1, 1'b0);
      end
   endtask

   task automatic encode_unit(input logic [15:0] c, input logic eos);
      bit is_low, is_high, bad;
      is_low = c >= LOW_FIRST && c <= LOW_LAST;
      is_high = c >= HIGH_FIRST && c <= HIGH_LAST;
      bad = 1'b0;
      if (str_failed) begin
         // drop everything up to the end of the string
      end else if (high_held) begin
         high_held = 1'b0;
         if (is_low) push_utf8({1'b0, held_bits, 10'b0} + 21'(c - LOW_FIRST) + 21'h10000);
         else bad = 1'b1;
         held_bits = '0;
      end else if (keeps_char(c)) begin
         push_word(c, 1'b1, 1'b0);
      end else if (is_low) begin
         bad = 1'b1;
      end else if (is_high) begin
         if (eos) begin
            bad = 1'b1;
         end else begin
            high_held = 1'b1;
            held_bits = c[9:0];
         end
      end else begin
         push_utf8({5'b0, c});
      end
      if (bad) begin
         push_word(16'h0000, 1'b1, 1'b1);
         str_failed = 1'b1;
         high_held = 1'b0;
         held_bits = '0;
      end
      if (eos) begin
         high_held = 1'b0;
         held_bits = '0;
         str_failed = 1'b0;
      end
   endtask

   // ---------------- sender side ----------------

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_unit(input logic [15:0] cu, input logic eos);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 2) == 0) gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cu;
      req_tlast <= eos;
      do @(posedge clock); while (!req_tready);
      encode_unit(cu, eos);
   endtask

   // drop valid, drain all expected words, then let the block settle
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      drain_block();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      comp_mode = v;
   endtask

   // ---------------- receiver, checker, watchdog ----------------

   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      enc_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: out_char %h last_of_run %b error_flag %b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want.ch) begin
               $error("out_char: expected %h, actual %h", want.ch, rsp_tdata);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %b, actual %b", want.last, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.err) begin
               $error("error_flag: expected %b, actual %b", want.err, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- tests ----------------

   task automatic test_full_set();
      send_unit(16'h0061, 1'b0);
      send_unit(16'h005A, 1'b0);
      send_unit(16'h0030, 1'b0);
      send_unit(16'h007E, 1'b0);
      send_unit(16'h003B, 1'b0);
      send_unit(16'h0023, 1'b1);
   endtask

   // one, two and three octet escapes at their range limits
   task automatic test_escapes();
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hFFFF, 1'b1);
   endtask

   task automatic test_surrogates();
      send_unit(HIGH_FIRST, 1'b0);
      send_unit(LOW_FIRST, 1'b0);
      send_unit(HIGH_LAST, 1'b0);
      send_unit(LOW_LAST, 1'b1);
      // lone low, then the rest of the string is dropped
      send_unit(LOW_FIRST, 1'b0);
      send_unit(16'h0061, 1'b0);
      send_unit(16'h0062, 1'b1);
      // high surrogate as the final unit
      send_unit(16'hD900, 1'b1);
      // held high followed by a plain character, and by another high
      send_unit(HIGH_FIRST, 1'b0);
      send_unit(16'h0078, 1'b1);
      send_unit(16'hDA00, 1'b0);
      send_unit(16'hDA01, 1'b1);
   endtask

   task automatic test_component_set();
      write_mode(MODE_COMP);
      send_unit(16'h003B, 1'b0);
      send_unit(16'h0023, 1'b0);
      send_unit(16'h002F, 1'b0);
      send_unit(16'h0021, 1'b0);
      send_unit(16'h0041, 1'b1);
   endtask

   // stall the result side for a long stretch while four-octet pairs keep coming
   task automatic test_backpressure();
      write_mode(MODE_FULL);
      gaps_on = 1'b0;
      hold_asked++;
      for (int i = 0; i < 12; i++) begin
         send_unit(16'hD83D, 1'b0);
         send_unit(LOW_FIRST + 16'(i * 85), i == 11);
      end
      gaps_on = 1'b1;
   endtask

   task automatic send_random_string(output int sent);
      logic [15:0] units[$];
      logic [15:0] u;
      int len, r;
      bit stop;
      len = $urandom_range(1, 6);
      stop = 1'b0;
      for (int i = 0; i < len && !stop; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            u = 16'($urandom_range(16'h20, 16'h7E));
            units.insert(units.size(), u);
         end else if (r < 35) begin
            u = {8'h00, punct_set[$urandom_range(0, punct_set.len() - 1)]};
            units.insert(units.size(), u);
         end else if (r < 42) begin
            u = 16'($urandom_range(0, 16'h1F));
            units.insert(units.size(), u);
         end else if (r < 57) begin
            u = 16'($urandom_range(16'h80, 16'h7FF));
            units.insert(units.size(), u);
         end else if (r < 70) begin
            u = 16'($urandom_range(16'h800, 16'hFFFF));
            if (u >= HIGH_FIRST && u <= LOW_LAST) u = u ^ 16'h4000;
            units.insert(units.size(), u);
         end else if (r < 86) begin
            u = HIGH_FIRST + 16'($urandom_range(0, 1023));
            units.insert(units.size(), u);
            u = LOW_FIRST + 16'($urandom_range(0, 1023));
            units.insert(units.size(), u);
         end else if (r < 94) begin
            u = 16'($urandom_range(0, 16'hFFFF));
            units.insert(units.size(), u);
         end else begin
            r = $urandom_range(0, 2);
            if (r == 0) begin
               u = LOW_FIRST + 16'($urandom_range(0, 1023));
               units.insert(units.size(), u);
            end else begin
               u = HIGH_FIRST + 16'($urandom_range(0, 1023));
               units.insert(units.size(), u);
               if (r == 1) begin
                  u = 16'($urandom_range(0, 16'hD7FF));
                  units.insert(units.size(), u);
               end else begin
                  stop = 1'b1;
               end
            end
         end
      end
      foreach (units[k]) send_unit(units[k], k == units.size() - 1);
      sent = units.size();
   endtask

   task automatic test_random_strings();
      int sent, n;
      for (int phase = 0; phase < 4; phase++) begin
         write_mode(phase[0] ? MODE_FULL : MODE_COMP);
         gaps_on = (phase != 2);
         n = 0;
         while (n < 24) begin
            send_random_string(sent);
            n += sent;
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_set();
      test_escapes();
      test_surrogates();
      test_component_set();
      test_backpressure();
      test_random_strings();
      drain_block();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
